FILE: rtl/qtc2_pkg.sv
package qtc2_pkg;

    // Number of output positions in the 2x2 kernel footprint
    localparam int NUM_POS = 4;

    // Position indexes
    localparam logic [1:0] POS_TOP_LEFT     = 2'd0;
    localparam logic [1:0] POS_BOTTOM_RIGHT = 2'd3;

    // Field widths
    localparam int VALUE_WIDTH = 8;
    localparam int WEIGHT_WIDTH = 8;
    localparam int MAC_WIDTH = VALUE_WIDTH + 1 + WEIGHT_WIDTH;
    localparam int SCALE_WIDTH = 32;
    localparam int BIAS_WIDTH = 64;
    localparam int SHIFT_WIDTH = 6;
    localparam int OUT_WIDTH = 8;
    localparam int HALF_WIDTH = 32;

    // Output clamp ceiling
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = 8'd255;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVATION_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_ZERO_POINT = 2'd1;

    // Requantization parameters carried with each finished pixel
    typedef struct packed {
        logic signed [SCALE_WIDTH-1:0]             scale;
        logic        [NUM_POS-1:0][BIAS_WIDTH-1:0] bias;
        logic        [SHIFT_WIDTH-1:0]             shift;
    } qtc2_rq_t;

endpackage

FILE: rtl/qtc2_front.sv
module qtc2_front
    import qtc2_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic [VALUE_WIDTH-1:0]                   in_value,
    input  logic [NUM_POS-1:0][WEIGHT_WIDTH-1:0]     weights,
    input  logic                                     last_channel,
    output logic                                     job_valid,
    input  logic                                     job_ready,
    output logic [NUM_POS-1:0][ACC_WIDTH-1:0]        job_sums
);

    logic [NUM_POS-1:0][ACC_WIDTH-1:0] sum_reg;
    logic [NUM_POS-1:0][ACC_WIDTH-1:0] sum_next;
    logic                              item_take;

    // Hold off the source while the job queue cannot take a finished pixel
    assign full      = !job_ready;
    assign item_take = push && job_ready;
    assign job_valid = item_take && last_channel;
    assign job_sums  = sum_next;

    // Multiply-accumulate the four kernel positions
    always_comb
    begin
        for (int k = 0; k < NUM_POS; k++)
        begin
            logic signed [MAC_WIDTH-1:0] mac;
            mac = $signed({1'b0, in_value}) * $signed(weights[k]);
            sum_next[k] = sum_reg[k] + {{(ACC_WIDTH-MAC_WIDTH){mac[MAC_WIDTH-1]}}, mac};
        end
    end

    // Advance the sums, clear them once the last channel is handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (item_take)
        begin
            if (last_channel)
            begin
                sum_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
            end
        end
    end

endmodule

FILE: rtl/qtc2_queue.sv
module qtc2_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_data
);

    localparam int DEPTH = 2;

    logic [DATA_WIDTH-1:0] entry_reg [DEPTH];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  wr_en;
    logic                  rd_en;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    // Store an incoming request
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/qtc2_back.sv
module qtc2_back
    import qtc2_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  logic [NUM_POS-1:0][ACC_WIDTH-1:0]  job_sums,
    input  qtc2_rq_t                           job_rq,
    input  logic                               activation_enable,
    input  logic [OUT_WIDTH-1:0]               output_zero_point,
    output logic                               empty,
    input  logic                               pop,
    output logic [NUM_POS-1:0][OUT_WIDTH-1:0]  out_bytes
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MLO   = 3'd1;
    localparam logic [2:0] ST_MHI   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_SHF   = 3'd4;
    localparam logic [2:0] ST_CLP   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [1:0]                          pos_reg;
    logic [NUM_POS-1:0][ACC_WIDTH-1:0]   sums_reg;
    qtc2_rq_t                            rq_reg;
    logic [BIAS_WIDTH-1:0]               prod_lo_reg;
    logic [HALF_WIDTH-1:0]               prod_hi_reg;
    logic [BIAS_WIDTH-1:0]               acc_reg;
    logic [HALF_WIDTH-1:0]               shf_reg;
    logic [NUM_POS-1:0][OUT_WIDTH-1:0]   bytes_reg;
    logic [NUM_POS-1:0][OUT_WIDTH-1:0]   out_reg;
    logic                                out_valid_reg;

    logic [BIAS_WIDTH-1:0]               sum_ext;
    logic signed [HALF_WIDTH:0]          mul_a;
    logic signed [HALF_WIDTH+SCALE_WIDTH:0] mul_p;
    logic signed [BIAS_WIDTH-1:0]        shifted;
    logic                                out_load;
    logic [OUT_WIDTH-1:0]                clamped;

    // Clamp a signed 32-bit value to [low, OUT_MAX]
    function automatic logic [OUT_WIDTH-1:0] clamp_byte(
        input logic [HALF_WIDTH-1:0] v,
        input logic                  act,
        input logic [OUT_WIDTH-1:0]  zp
    );
        logic signed [HALF_WIDTH-1:0] sv;
        logic signed [HALF_WIDTH-1:0] lo;
        logic signed [HALF_WIDTH-1:0] hi;
        logic [OUT_WIDTH-1:0]         res;
        sv = $signed(v);
        lo = act ? $signed({{(HALF_WIDTH-OUT_WIDTH){1'b0}}, zp}) : '0;
        hi = $signed({{(HALF_WIDTH-OUT_WIDTH){1'b0}}, OUT_MAX});
        if (sv < lo)
        begin
            res = lo[OUT_WIDTH-1:0];
        end
        else if (sv > hi)
        begin
            res = OUT_MAX;
        end
        else
        begin
            res = sv[OUT_WIDTH-1:0];
        end
        return res;
    endfunction

    assign job_ready = (state_reg == ST_IDLE);
    assign empty     = !out_valid_reg;
    assign out_bytes = out_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || pop);

    // Shared multiplier: low half unsigned in the first pass, high half signed in the second
    assign sum_ext = {{(BIAS_WIDTH-ACC_WIDTH){sums_reg[pos_reg][ACC_WIDTH-1]}},
                      sums_reg[pos_reg]};
    assign mul_a   = (state_reg == ST_MHI)
                   ? $signed({sum_ext[BIAS_WIDTH-1], sum_ext[BIAS_WIDTH-1:HALF_WIDTH]})
                   : $signed({1'b0, sum_ext[HALF_WIDTH-1:0]});
    assign mul_p   = mul_a * rq_reg.scale;
    assign shifted = $signed(acc_reg) >>> rq_reg.shift;
    assign clamped = clamp_byte(shf_reg, activation_enable, output_zero_point);

    // Sequence the four positions through multiply, add, shift and clamp
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_MLO;
                end
            end
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_SHF;
            ST_SHF:  state_next = ST_CLP;
            ST_CLP:
            begin
                state_next = (pos_reg == POS_BOTTOM_RIGHT) ? ST_DONE : ST_MLO;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_TOP_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                pos_reg <= POS_TOP_LEFT;
            end
            else if (state_reg == ST_CLP)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    sums_reg <= job_sums;
                    rq_reg   <= job_rq;
                end
            end
            ST_MLO:
            begin
                prod_lo_reg <= mul_p[BIAS_WIDTH-1:0];
            end
            ST_MHI:
            begin
                prod_hi_reg <= mul_p[HALF_WIDTH-1:0];
                acc_reg     <= prod_lo_reg + rq_reg.bias[pos_reg];
            end
            ST_ADD:
            begin
                acc_reg[BIAS_WIDTH-1:HALF_WIDTH] <= acc_reg[BIAS_WIDTH-1:HALF_WIDTH]
                                                  + prod_hi_reg;
            end
            ST_SHF:
            begin
                shf_reg <= shifted[HALF_WIDTH-1:0];
            end
            ST_CLP:
            begin
                bytes_reg[pos_reg] <= clamped;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg <= bytes_reg;
        end
    end

endmodule

FILE: rtl/quantized_transpose_conv_2x2_core.sv
// 2x2 stride-2 transposed convolution core for one pixel and one output channel.
// Push one input channel (value plus four weights) per item; items with
// last_channel low are taken one per cycle unless full and give no result.
// An item with last_channel high closes the pixel: its four sums go into a
// two-entry queue and the accumulators restart at zero, so the next pixel
// can stream in at once. A back-end sequencer requantizes the four positions
// into a four-byte result through one shared 33x32 multiplier, five steps per
// position (low multiply, high multiply, add, shift, clamp); pixels closing
// faster than it finishes them fill the queue and raise full. Configuration
// (activation_enable at index 0, output_zero_point at index 1, other indexes
// ignored) is always ready and must be written only while the block is idle.
module quantized_transpose_conv_2x2_core
    import qtc2_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [VALUE_WIDTH-1:0]       in_value,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_top_left,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_top_right,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_bottom_left,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_bottom_right,
    input  logic                         last_channel,
    input  logic signed [SCALE_WIDTH-1:0] scale,
    input  logic signed [BIAS_WIDTH-1:0] bias_top_left,
    input  logic signed [BIAS_WIDTH-1:0] bias_top_right,
    input  logic signed [BIAS_WIDTH-1:0] bias_bottom_left,
    input  logic signed [BIAS_WIDTH-1:0] bias_bottom_right,
    input  logic [SHIFT_WIDTH-1:0]       shift_amount,
    output logic                         empty,
    input  logic                         pop,
    output logic [OUT_WIDTH-1:0]         out_top_left,
    output logic [OUT_WIDTH-1:0]         out_top_right,
    output logic [OUT_WIDTH-1:0]         out_bottom_left,
    output logic [OUT_WIDTH-1:0]         out_bottom_right,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int SUMS_WIDTH = NUM_POS * ACC_WIDTH;
    localparam int JOB_WIDTH  = SUMS_WIDTH + $bits(qtc2_rq_t);

    logic                              activation_enable_reg;
    logic [OUT_WIDTH-1:0]              output_zero_point_reg;
    logic [NUM_POS-1:0][WEIGHT_WIDTH-1:0] weights;
    logic                              f_job_valid;
    logic                              q_in_ready;
    logic [NUM_POS-1:0][ACC_WIDTH-1:0] f_job_sums;
    qtc2_rq_t                          f_rq;
    logic [JOB_WIDTH-1:0]              q_in_data;
    logic [JOB_WIDTH-1:0]              q_out_data;
    logic                              q_out_valid;
    logic                              b_job_ready;
    logic [NUM_POS-1:0][ACC_WIDTH-1:0] b_job_sums;
    qtc2_rq_t                          b_rq;
    logic [NUM_POS-1:0][OUT_WIDTH-1:0] out_bytes;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            activation_enable_reg <= 1'b0;
            output_zero_point_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVATION_ENABLE: activation_enable_reg <= cfg_data[0];
                REG_OUTPUT_ZERO_POINT: output_zero_point_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Gather per-position fields
    assign weights[0] = weight_top_left;
    assign weights[1] = weight_top_right;
    assign weights[2] = weight_bottom_left;
    assign weights[3] = weight_bottom_right;

    assign f_rq.scale   = scale;
    assign f_rq.bias[0] = bias_top_left;
    assign f_rq.bias[1] = bias_top_right;
    assign f_rq.bias[2] = bias_bottom_left;
    assign f_rq.bias[3] = bias_bottom_right;
    assign f_rq.shift   = shift_amount;

    qtc2_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_value     (in_value),
        .weights      (weights),
        .last_channel (last_channel),
        .job_valid    (f_job_valid),
        .job_ready    (q_in_ready),
        .job_sums     (f_job_sums)
    );

    assign q_in_data = {f_job_sums, f_rq};

    qtc2_queue #(
        .DATA_WIDTH (JOB_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_job_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (b_job_ready),
        .out_data  (q_out_data)
    );

    assign b_job_sums = q_out_data[JOB_WIDTH-1 -: SUMS_WIDTH];
    assign b_rq       = q_out_data[$bits(qtc2_rq_t)-1:0];

    qtc2_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_valid         (q_out_valid),
        .job_ready         (b_job_ready),
        .job_sums          (b_job_sums),
        .job_rq            (b_rq),
        .activation_enable (activation_enable_reg),
        .output_zero_point (output_zero_point_reg),
        .empty             (empty),
        .pop               (pop),
        .out_bytes         (out_bytes)
    );

    assign out_top_left     = out_bytes[0];
    assign out_top_right    = out_bytes[1];
    assign out_bottom_left  = out_bytes[2];
    assign out_bottom_right = out_bytes[3];

`ifndef ASSERT_OFF
    // A closed pixel must land in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && last_channel) |=> q_out_valid)
    else $error("closed pixel did not reach the job queue");

    // The back end is busy right after it takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_out_valid && b_job_ready) |=> !b_job_ready)
    else $error("back end took a request but stayed idle");

    // Input is held off exactly when the queue has no room
    assert property (@(posedge clk) disable iff (!rst_n)
        full == !q_in_ready)
    else $error("full does not track queue room");
`endif

endmodule

FILE: tb/tb.sv
module tb
    import qtc2_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Positions not named by the package
    localparam logic [1:0] POS_TOP_RIGHT   = 2'd1;
    localparam logic [1:0] POS_BOTTOM_LEFT = 2'd2;

    // Register indexes outside the map, writes must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_CHANNELS = 200;
    localparam int PHASE_CHANS   = 110;
    localparam int TIMEOUT_NS    = 20_000_000;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]                  value;
        logic [NUM_POS-1:0][WEIGHT_WIDTH-1:0]    weight;
        logic                                    last;
        logic [SCALE_WIDTH-1:0]                  scale;
        logic [NUM_POS-1:0][BIAS_WIDTH-1:0]      bias;
        logic [SHIFT_WIDTH-1:0]                  shift;
    } channel_t;

    typedef logic [NUM_POS-1:0][OUT_WIDTH-1:0] pixel_t;

    logic clk;
    logic rst_n = 1'b0;

    logic     push     = 1'b0;
    logic     pop      = 1'b0;
    channel_t drv_chan = '0;
    logic     full;
    logic     empty;
    logic [OUT_WIDTH-1:0] out_top_left;
    logic [OUT_WIDTH-1:0] out_top_right;
    logic [OUT_WIDTH-1:0] out_bottom_left;
    logic [OUT_WIDTH-1:0] out_bottom_right;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    // Channels waiting to be pushed, pixels waiting to be popped
    channel_t chan_q[$];
    pixel_t   pixel_q[$];

    // Shadow of the block: running sums and the two registers
    int               pos_sum[NUM_POS] = '{default: 0};
    logic             act_en  = 1'b0;
    logic [7:0]       zero_pt = 8'd0;

    logic req_taken = 1'b0;
    int   fail_count = 0;
    int   burst_left = 0;
    int   gap_left   = 0;
    int   run_left   = 0;
    int   hold_left  = 0;

    quantized_transpose_conv_2x2_core #(
        .ACC_WIDTH(32)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .in_value           (drv_chan.value),
        .weight_top_left    (drv_chan.weight[POS_TOP_LEFT]),
        .weight_top_right   (drv_chan.weight[POS_TOP_RIGHT]),
        .weight_bottom_left (drv_chan.weight[POS_BOTTOM_LEFT]),
        .weight_bottom_right(drv_chan.weight[POS_BOTTOM_RIGHT]),
        .last_channel       (drv_chan.last),
        .scale              (drv_chan.scale),
        .bias_top_left      (drv_chan.bias[POS_TOP_LEFT]),
        .bias_top_right     (drv_chan.bias[POS_TOP_RIGHT]),
        .bias_bottom_left   (drv_chan.bias[POS_BOTTOM_LEFT]),
        .bias_bottom_right  (drv_chan.bias[POS_BOTTOM_RIGHT]),
        .shift_amount       (drv_chan.shift),
        .empty              (empty),
        .pop                (pop),
        .out_top_left       (out_top_left),
        .out_top_right      (out_top_right),
        .out_bottom_left    (out_bottom_left),
        .out_bottom_right   (out_bottom_right),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Scale, add bias, shift, keep low word, clamp to the output range
    function automatic logic [7:0] requantize(int sum, int scl, longint bias,
                                              logic [5:0] sh);
        longint prod;
        int     word;
        int     floor_val;
        prod = longint'(sum) * longint'(scl) + bias;
        prod = prod >>> sh;
        word = prod[31:0];
        floor_val = act_en ? int'(zero_pt) : 0;
        if (word < floor_val)
            word = floor_val;
        if (word > int'(OUT_MAX))
            word = int'(OUT_MAX);
        return word[7:0];
    endfunction

    // Accumulate one channel; close the pixel on the last one
    function automatic void take_channel(channel_t ch);
        pixel_t px;
        int     k;
        for (k = 0; k < NUM_POS; k++)
            pos_sum[k] += int'(ch.value) * int'($signed(ch.weight[k]));
        if (ch.last) begin
            for (k = 0; k < NUM_POS; k++) begin
                px[k] = requantize(pos_sum[k], int'(ch.scale), longint'(ch.bias[k]),
                                   ch.shift);
                pos_sum[k] = 0;
            end
            pixel_q.push_back(px);
        end
    endfunction

    function automatic channel_t make_channel(logic [7:0] v, logic [31:0] w, bit last,
                                              logic [31:0] scl, logic [63:0] b,
                                              logic [5:0] sh);
        channel_t ch;
        ch.value  = v;
        ch.weight = w;
        ch.last   = last;
        ch.scale  = scl;
        ch.bias   = {NUM_POS{b}};
        ch.shift  = sh;
        return ch;
    endfunction

    // Random channel; tame ones pick scale, bias and shift so results land in range
    function automatic channel_t random_channel(bit last, bit tame);
        channel_t ch;
        int       k;
        int       sh;
        int       scale_cut;
        int       bias_cut;
        ch.value = ($urandom_range(0, 7) == 0) ?
                   (($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00) : 8'($urandom);
        for (k = 0; k < NUM_POS; k++) begin
            case ($urandom_range(0, 7))
                0:       ch.weight[k] = 8'h80;
                1:       ch.weight[k] = 8'h7F;
                2:       ch.weight[k] = 8'h00;
                default: ch.weight[k] = 8'($urandom);
            endcase
        end
        ch.last  = last;
        ch.scale = $urandom;
        for (k = 0; k < NUM_POS; k++)
            ch.bias[k] = {$urandom, $urandom};
        ch.shift = 6'($urandom);
        if (tame) begin
            sh = int'($urandom_range(0, 40));
            scale_cut = 38 - sh + int'($urandom_range(0, 8));
            if (scale_cut < 0)
                scale_cut = 0;
            if (scale_cut > 31)
                scale_cut = 31;
            bias_cut = 54 - sh + int'($urandom_range(0, 6));
            if (bias_cut > 63)
                bias_cut = 63;
            ch.shift = sh[5:0];
            ch.scale = $signed(ch.scale) >>> scale_cut;
            for (k = 0; k < NUM_POS; k++)
                ch.bias[k] = $signed(ch.bias[k]) >>> bias_cut;
        end
        return ch;
    endfunction

    // Queue whole pixels of random depth until n_chans channels are queued
    task automatic queue_pixels(int n_chans);
        int queued;
        int depth;
        int c;
        bit tame;
        queued = 0;
        while (queued < n_chans) begin
            depth = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40)) :
                                                  int'($urandom_range(1, 12));
            tame = ($urandom_range(0, 9) < 7);
            for (c = 0; c < depth; c++)
                chan_q.push_back(random_channel(c == depth - 1, tame));
            queued += depth;
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                             logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_ACTIVATION_ENABLE)
            act_en = data[0];
        else if (idx == REG_OUTPUT_ZERO_POINT)
            zero_pt = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued channel is in and every pixel is out
    task automatic wait_idle();
        while (chan_q.size() != 0 || push || pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("quantized_transpose_conv_2x2_core test failed");
        $finish;
    end

    // Sender: bursts of requests separated by random gaps
    always @(negedge clk) begin
        if (push && !req_taken) begin
            // hold the current request
        end else if (gap_left > 0 || chan_q.size() == 0) begin
            push <= 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
        end else begin
            drv_chan <= chan_q.pop_front();
            push <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= int'($urandom_range(1, 32));
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: runs of pop with stalls of random length
    always @(negedge clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            pop <= 1'b1;
            if (run_left <= 1) begin
                run_left <= int'($urandom_range(1, 24));
                hold_left <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 30));
            end else begin
                run_left <= run_left - 1;
            end
        end
    end

    // Monitor: predict on accepted requests, check popped pixels
    always @(posedge clk) begin : monitor
        pixel_t got;
        pixel_t want;
        int     k;
        req_taken <= push && !full;
        if (rst_n && push && !full)
            take_channel(drv_chan);
        if (rst_n && pop && !empty) begin
            got = {out_bottom_right, out_bottom_left, out_top_right, out_top_left};
            if (pixel_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected pixel at %0t: got %h", $realtime, got);
            end else begin
                want = pixel_q.pop_front();
                for (k = 0; k < NUM_POS; k++) begin
                    if (got[k] !== want[k]) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at %0t: position %0d expected %0d got %0d",
                                     $realtime, k, want[k], got[k]);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        channel_t   ch;
        int         n;
        int         p;
        logic       act_set[6];
        logic [7:0] zp_set[6];

        act_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        zp_set  = '{8'd255, 8'd0, 8'd200, 8'd128, 8'($urandom), 8'd0};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, single-channel pixel
        chan_q.push_back(make_channel(8'hFF, {8'hFF, 8'h00, 8'h7F, 8'h80}, 1'b1,
                                      32'd1, 64'd0, 6'd0));
        // Zero input with junk requant fields on a non-last channel
        chan_q.push_back(make_channel(8'h00, {4{8'h7F}}, 1'b0,
                                      32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'h3F));
        chan_q.push_back(make_channel(8'd10, {8'hFE, 8'd1, 8'd3, 8'd5}, 1'b1,
                                      32'd3, 64'd10, 6'd1));
        // Low word kept, upper bits of the 64-bit value dropped
        ch = make_channel(8'd1, {4{8'd1}}, 1'b1, 32'd1, 64'd0, 6'd0);
        ch.bias[POS_TOP_LEFT]     = 64'h0000_0001_0000_0063;
        ch.bias[POS_TOP_RIGHT]    = 64'h0000_0000_7FFF_FFFF;
        ch.bias[POS_BOTTOM_LEFT]  = 64'hFFFF_FFFF_0000_00C7;
        ch.bias[POS_BOTTOM_RIGHT] = 64'h7FFF_FFFF_FFFF_FFFF;
        chan_q.push_back(ch);
        // Bias add wraps past the top of 64 bits
        chan_q.push_back(make_channel(8'hFF, {4{8'h7F}}, 1'b1,
                                      32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 6'd62));
        // Most negative scale and bias, widest shift
        chan_q.push_back(make_channel(8'hFF, {4{8'h80}}, 1'b1,
                                      32'h8000_0000, 64'h8000_0000_0000_0000, 6'd63));
        chan_q.push_back(make_channel(8'd1, {4{8'hFF}}, 1'b1,
                                      32'h8000_0000, 64'd0, 6'd23));
        chan_q.push_back(make_channel(8'd1, {4{8'hFF}}, 1'b1,
                                      32'h8000_0000, 64'd0, 6'd24));
        chan_q.push_back(make_channel(8'hFF, {4{8'h7F}}, 1'b1,
                                      32'h7FFF_FFFF, 64'd0, 6'd63));
        // Short multi-channel pixels with random content
        for (n = 0; n < 12; n++)
            chan_q.push_back(random_channel(n % 4 == 3, 1'b1));
        wait_idle();

        // One long pixel at the weight extremes, driving the sums far both ways
        for (n = 0; n < LONG_CHANNELS; n++) begin
            ch = random_channel(n == LONG_CHANNELS - 1, 1'b0);
            ch.value = 8'hFF;
            ch.weight[POS_TOP_LEFT]  = 8'h80;
            ch.weight[POS_TOP_RIGHT] = 8'h7F;
            if (ch.last) begin
                ch.scale = 32'd1;
                ch.bias  = '0;
                ch.shift = 6'd0;
            end
            chan_q.push_back(ch);
        end
        wait_idle();

        // Random pixels under a sweep of register settings
        for (p = 0; p < 6; p++) begin
            write_reg(REG_ACTIVATION_ENABLE, {7'($urandom), act_set[p]});
            write_reg(REG_OUTPUT_ZERO_POINT, zp_set[p]);
            if (p == 2 || p == 5) begin
                write_reg(REG_SPARE_A, 8'($urandom));
                write_reg(REG_SPARE_B, 8'($urandom));
            end
            queue_pixels(PHASE_CHANS);
            // pause the sender until everything is out
            while (chan_q.size() != 0 || push || pixel_q.size() != 0)
                @(posedge clk);
            queue_pixels(PHASE_CHANS);
            wait_idle();
        end

        if (fail_count == 0)
            $display("quantized_transpose_conv_2x2_core test passed");
        else
            $display("quantized_transpose_conv_2x2_core test failed");
        $finish;
    end

endmodule
